>>> rtl/core/tcq_pkg.sv
// ----------------------------------------------------------------------------
// tcq_pkg: shared types and constants for the two-class queue
// Entry layout, command and status codes, and the broadcast bundle that the
// controller drives into every queue cell.
// ----------------------------------------------------------------------------
package tcq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FLIGHT_W    = 14;
  localparam int ORIGIN_W    = 16;
  localparam int STATUS_W    = 3;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_SERVE   = 2'd1,
    CMD_PROMOTE = 2'd2,
    CMD_DRAIN   = 2'd3
  } command_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_SERVED    = 3'd0,
    STAT_NOTHING   = 3'd1,
    STAT_LISTED    = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_FULL      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_ENQ     = 2'd1,
    CELL_SHIFT   = 2'd2,
    CELL_PROMOTE = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [FLIGHT_W-1:0] flight;
    logic [ORIGIN_W-1:0] origin;
    logic                urgent;
  } entry_t;

  // Flight doubles as the new entry's number on enqueue and the search key
  // on promote.
  typedef struct packed {
    cell_op_e            op;
    logic [FLIGHT_W-1:0] flight;
    logic [ORIGIN_W-1:0] origin;
    entry_t              found;
    logic                move;
  } cell_bcast_t;

endpackage

>>> rtl/core/tcq_cell.sv
// ----------------------------------------------------------------------------
// tcq_cell: one position of the queue
// Holds one entry and updates it from its neighbors or from the broadcast
// bundle; passes the first-match and urgent-boundary chains to the next cell.
// ----------------------------------------------------------------------------
module tcq_cell import tcq_pkg::*; (
  input  logic        clk_i,
  input  cell_bcast_t bcast_i,
  input  entry_t      left_i,
  input  entry_t      right_i,
  input  logic        occ_i,
  input  logic        prev_occ_i,
  input  logic        prev_urg_i,
  input  logic        seen_i,
  input  logic        after_b_i,
  output entry_t      entry_o,
  output logic        urg_o,
  output logic        seen_o,
  output logic        after_b_o,
  output logic        first_o,
  output logic        first_after_b_o
);

  entry_t entry_q, entry_d;
  logic   match;
  logic   boundary;

  assign urg_o    = occ_i & entry_q.urgent;
  // The first non-urgent position; the urgent section is always contiguous.
  assign boundary = prev_urg_i & ~urg_o;
  assign match    = occ_i & (entry_q.flight == bcast_i.flight);

  assign first_o         = match & ~seen_i;
  assign first_after_b_o = first_o & after_b_i;
  assign seen_o          = seen_i | match;
  assign after_b_o       = after_b_i | boundary;
  assign entry_o         = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (bcast_i.op)
      CELL_ENQ: begin
        if (!occ_i && prev_occ_i) begin
          entry_d.flight = bcast_i.flight;
          entry_d.origin = bcast_i.origin;
          entry_d.urgent = 1'b0;
        end
      end
      CELL_SHIFT: entry_d = right_i;
      CELL_PROMOTE: begin
        if (bcast_i.move) begin
          // Open a slot at the boundary and slide the stretch up to the
          // matching entry one place toward the tail.
          if (boundary) begin
            entry_d        = bcast_i.found;
            entry_d.urgent = 1'b1;
          end else if (after_b_i && !seen_i) begin
            entry_d = left_i;
          end
        end else if (first_o) begin
          entry_d.urgent = 1'b1;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> rtl/core/two_class_queue_with_promotion.sv
// ----------------------------------------------------------------------------
// two_class_queue_with_promotion: bounded queue with an urgent front section
// Enqueue and serve finish on acceptance; any result shows on the next cycle.
// Promote is accepted first, then a compare and shift runs across all cells.
// Drain is accepted, then lists each stored entry while the output is free,
// each result moving through the output register as the chain shifts left.
// Reset clears the fill count and control state; entries are not reset.
// ----------------------------------------------------------------------------
module two_class_queue_with_promotion import tcq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [FLIGHT_W-1:0] flight_id_i,
  input  logic [ORIGIN_W-1:0] origin_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [FLIGHT_W-1:0] out_flight_o,
  output logic [ORIGIN_W-1:0] out_origin_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                last_o
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_PROMOTE = 3'b010,
    ST_DRAIN   = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [FLIGHT_W-1:0] key_q, key_d;

  logic                out_valid_q, out_valid_d;
  logic [FLIGHT_W-1:0] out_flight_q, out_flight_d;
  logic [ORIGIN_W-1:0] out_origin_q, out_origin_d;
  status_e             status_q, status_d;
  logic                last_q, last_d;

  cell_bcast_t bcast;
  entry_t      cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ, urg, first, first_after_b;
  logic [QUEUE_DEPTH:0]   seen_chain, after_b_chain;

  logic   out_free, accept, found_any, full, empty;
  entry_t found_entry;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);

  assign seen_chain[0]    = 1'b0;
  assign after_b_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   prev_occ, prev_urg;

    assign occ[i] = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_e   = cell_entry[i];
      assign prev_occ = 1'b1;
      assign prev_urg = 1'b1;
    end else begin : g_body
      assign left_e   = cell_entry[i-1];
      assign prev_occ = occ[i-1];
      assign prev_urg = urg[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    tcq_cell u_cell (
      .clk_i          (clk_i),
      .bcast_i        (bcast),
      .left_i         (left_e),
      .right_i        (right_e),
      .occ_i          (occ[i]),
      .prev_occ_i     (prev_occ),
      .prev_urg_i     (prev_urg),
      .seen_i         (seen_chain[i]),
      .after_b_i      (after_b_chain[i]),
      .entry_o        (cell_entry[i]),
      .urg_o          (urg[i]),
      .seen_o         (seen_chain[i+1]),
      .after_b_o      (after_b_chain[i+1]),
      .first_o        (first[i]),
      .first_after_b_o(first_after_b[i])
    );
  end

  // At most one cell flags the first match, so an OR picks its entry.
  always_comb begin
    found_entry = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (first[i]) found_entry = found_entry | cell_entry[i];
    end
  end

  assign found_any = |first;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    key_d        = key_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_flight_d = out_flight_q;
    out_origin_d = out_origin_q;
    status_d     = status_q;
    last_d       = last_q;

    bcast.op     = CELL_HOLD;
    bcast.flight = flight_id_i;
    bcast.origin = origin_code_i;
    bcast.found  = found_entry;
    bcast.move   = |first_after_b;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (command_e'(command_i))
            CMD_ENQUEUE: begin
              if (full) begin
                out_valid_d  = 1'b1;
                out_flight_d = '0;
                out_origin_d = '0;
                status_d     = STAT_FULL;
                last_d       = 1'b1;
              end else begin
                bcast.op = CELL_ENQ;
                count_d  = count_q + 1'b1;
              end
            end
            CMD_SERVE: begin
              out_valid_d = 1'b1;
              last_d      = 1'b1;
              if (empty) begin
                out_flight_d = '0;
                out_origin_d = '0;
                status_d     = STAT_NOTHING;
              end else begin
                out_flight_d = cell_entry[0].flight;
                out_origin_d = cell_entry[0].origin;
                status_d     = STAT_SERVED;
                bcast.op     = CELL_SHIFT;
                count_d      = count_q - 1'b1;
              end
            end
            CMD_PROMOTE: begin
              key_d   = flight_id_i;
              state_d = ST_PROMOTE;
            end
            default: begin
              if (empty) begin
                out_valid_d  = 1'b1;
                out_flight_d = '0;
                out_origin_d = '0;
                status_d     = STAT_EMPTY;
                last_d       = 1'b1;
              end else begin
                state_d = ST_DRAIN;
              end
            end
          endcase
        end
      end
      ST_PROMOTE: begin
        // The output register is known to be free here: it was free when
        // the item was taken and nothing has been loaded since.
        bcast.op     = CELL_PROMOTE;
        bcast.flight = key_q;
        state_d      = ST_IDLE;
        if (!found_any) begin
          out_valid_d  = 1'b1;
          out_flight_d = '0;
          out_origin_d = '0;
          status_d     = STAT_NOT_FOUND;
          last_d       = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_flight_d = cell_entry[0].flight;
          out_origin_d = cell_entry[0].origin;
          status_d     = STAT_LISTED;
          last_d       = (count_q == CNT_W'(1));
          bcast.op     = CELL_SHIFT;
          count_d      = count_q - 1'b1;
          if (count_q == CNT_W'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    out_flight_q <= out_flight_d;
    out_origin_q <= out_origin_d;
    status_q     <= status_d;
    last_q       <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_flight_o = out_flight_q;
  assign out_origin_o = out_origin_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule
